/* rtl/core/snp_haplotype_vote_over_alignment_core_assert.svh */
// Assertion macros shared by the core
`ifndef SNP_HAPLOTYPE_VOTE_OVER_ALIGNMENT_CORE_ASSERT_SVH
`define SNP_HAPLOTYPE_VOTE_OVER_ALIGNMENT_CORE_ASSERT_SVH

// Same-cycle implication
`define SNP_HV_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SNP_HV_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/snp_hv_pkg.sv */
package snp_hv_pkg;

	localparam int MAX_RADIUS = 8;
	localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
	localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
	localparam int IDX_W      = $clog2(WIN_DEPTH);
	localparam int VOTE_W     = 16;

	localparam int RADIUS_CFG_W = 4;
	localparam int MAPQ_W       = 8;
	localparam int IDENT_W      = 14;
	localparam int BASE_W       = 8;
	localparam int TAG_W        = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 14;
	localparam int IN_DATA_W    = 56;
	localparam int OUT_DATA_W   = 8;

	localparam logic [MAPQ_W-1:0] LOOSE_MIN_MAPQ = 8'd5;

	localparam logic [RADIUS_CFG_W-1:0] RADIUS_RESET  = 4'd3;
	localparam logic [MAPQ_W-1:0]       MIN_MAPQ_RESET = 8'd5;
	localparam logic [IDENT_W-1:0]      MIN_IDENT_RESET = 14'd8500;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MAP_QUALITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_IDENTITY    = 2'd2;

	localparam logic [TAG_W-1:0] TAG_NONE = 2'd0;
	localparam logic [TAG_W-1:0] TAG_HAP1 = 2'd1;
	localparam logic [TAG_W-1:0] TAG_HAP2 = 2'd2;

	// One alignment column held in a cell (valid bit kept apart)
	typedef struct packed {
		logic [BASE_W-1:0] qb;
		logic              qgap;
		logic [BASE_W-1:0] rb;
		logic              rgap;
		logic              snp;
		logic [BASE_W-1:0] alt;
		logic              rph;
		logic              aph;
	} column_t;

	// Vote produced by the judge for one column
	typedef struct packed {
		logic loose;
		logic strict;
		logic hap_two;
	} vote_t;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_FLUSH = 3'b010,
		ST_TAG   = 3'b100
	} state_t;

endpackage

/* rtl/core/snp_hv_cell.sv */
module snp_hv_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  logic                clear,
	input  logic                in_valid,
	input  snp_hv_pkg::column_t in_col,
	output logic                out_valid,
	output snp_hv_pkg::column_t out_col,
	output logic                ok
);
	import snp_hv_pkg::*;

	logic    valid_q;
	column_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= in_col;
		end
	end

	// Empty and SNP cells never spoil a neighbor's window
	assign ok = !valid_q || col_q.snp ||
		((col_q.qgap == col_q.rgap) && (col_q.qgap || (col_q.qb == col_q.rb)));

	assign out_valid = valid_q;
	assign out_col   = col_q;

endmodule

/* rtl/core/snp_hv_judge.sv */
module snp_hv_judge (
	input  logic                                    en,
	input  logic [snp_hv_pkg::RAD_W-1:0]            radius,
	input  logic [snp_hv_pkg::WIN_DEPTH-1:0]        valids,
	input  logic [snp_hv_pkg::WIN_DEPTH-1:0]        oks,
	input  snp_hv_pkg::column_t                     cols [snp_hv_pkg::WIN_DEPTH],
	output snp_hv_pkg::vote_t                       vote
);
	import snp_hv_pkg::*;

	logic [IDX_W-1:0] sel_idx;
	column_t          sel;
	logic             sel_v;
	logic             hit_ref;
	logic             hit_alt;
	logic             sides_ok;

	assign sel_idx = IDX_W'(radius);
	assign sel     = cols[sel_idx];
	assign sel_v   = valids[sel_idx];
	assign hit_ref = (sel.qb == sel.rb);
	assign hit_alt = (sel.qb == sel.alt);

	// Window spans cells 0 .. 2*radius around the judged cell
	always_comb begin
		sides_ok = 1'b1;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if ((i <= 2 * int'(radius)) && (i != int'(radius)) && !oks[i]) begin
				sides_ok = 1'b0;
			end
		end
	end

	always_comb begin
		vote.loose   = en && sel_v && sel.snp && !sel.qgap && (hit_ref || hit_alt);
		vote.strict  = vote.loose && sides_ok;
		vote.hap_two = hit_ref ? sel.rph : sel.aph;
	end

endmodule

/* rtl/core/snp_hv_tally.sv */
module snp_hv_tally (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clear,
	input  snp_hv_pkg::vote_t                vote,
	output logic [snp_hv_pkg::TAG_W-1:0]     strict_dec,
	output logic [snp_hv_pkg::TAG_W-1:0]     loose_dec,
	output logic                             empty
);
	import snp_hv_pkg::*;

	localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

	logic [VOTE_W-1:0] strict_one_q, strict_two_q, loose_one_q, loose_two_q;

	function automatic logic [VOTE_W-1:0] sat_inc(input logic [VOTE_W-1:0] c);
		return (c == VOTE_MAX) ? c : c + VOTE_W'(1);
	endfunction

	function automatic logic [TAG_W-1:0] decide(input logic [VOTE_W-1:0] one,
		input logic [VOTE_W-1:0] two);
		logic [TAG_W-1:0] t;
		if (one > two) t = TAG_HAP1;
		else if (one < two) t = TAG_HAP2;
		else t = TAG_NONE;
		return t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_one_q <= '0;
			strict_two_q <= '0;
			loose_one_q  <= '0;
			loose_two_q  <= '0;
		end else if (clear) begin
			strict_one_q <= '0;
			strict_two_q <= '0;
			loose_one_q  <= '0;
			loose_two_q  <= '0;
		end else begin
			if (vote.loose && !vote.hap_two) loose_one_q <= sat_inc(loose_one_q);
			if (vote.loose && vote.hap_two) loose_two_q <= sat_inc(loose_two_q);
			if (vote.strict && !vote.hap_two) strict_one_q <= sat_inc(strict_one_q);
			if (vote.strict && vote.hap_two) strict_two_q <= sat_inc(strict_two_q);
		end
	end

	assign strict_dec = decide(strict_one_q, strict_two_q);
	assign loose_dec  = decide(loose_one_q, loose_two_q);
	assign empty = (strict_one_q == '0) && (strict_two_q == '0) &&
		(loose_one_q == '0) && (loose_two_q == '0);

endmodule

/* rtl/core/snp_haplotype_vote_over_alignment_core.sv */
// Channel | Direction | Beat contents
// s_*     | in        | one alignment column; tlast marks the fragment's last column
// m_*     | out       | strict and loose haplotype tags, one beat per fragment
// cfg_*   | in        | register write: window_radius, min_map_quality, min_identity
//
// One column per cycle while in the run state; a column is judged while it sits in cell radius after a shift.
// After the last column the chain shifts radius empty slots to judge the trailing
// columns, then the tag step forms the tags; no column is taken during flush and tag.
// A tag held by low m_tready stalls only the next fragment's tag step.
// arst_n clears valid bits, vote counters, control state and loads register defaults.
`include "snp_haplotype_vote_over_alignment_core_assert.svh"

module snp_haplotype_vote_over_alignment_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// query_base, query_gap, ref_base, ref_gap, snp_here, snp_alt_base,
	// ref_phase, alt_phase, map_quality, identity, zero fill
	input  logic [snp_hv_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// strict_tag, loose_tag, zero fill
	output logic [snp_hv_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                                 cfg_we,
	input  logic [snp_hv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [snp_hv_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import snp_hv_pkg::*;

	state_t state_q;

	logic [RADIUS_CFG_W-1:0] window_radius_q;
	logic [MAPQ_W-1:0]       min_mapq_q;
	logic [IDENT_W-1:0]      min_ident_q;

	logic [RAD_W-1:0]   r_eff;
	logic [RAD_W-1:0]   flush_cnt_q;
	logic               judge_q;
	logic [MAPQ_W-1:0]  mapq_q;
	logic [IDENT_W-1:0] ident_q;

	logic accept;
	logic shift;
	logic clear;
	logic out_load;

	column_t                in_col;
	column_t                cols [WIN_DEPTH];
	logic [WIN_DEPTH-1:0]   valids;
	logic [WIN_DEPTH-1:0]   oks;
	vote_t                  vote;

	logic [TAG_W-1:0] strict_dec, loose_dec;
	logic             tally_empty;
	logic             frag_idle;
	logic             m_tvalid_q;
	logic [TAG_W-1:0] strict_tag_q, loose_tag_q;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_radius_q <= RADIUS_RESET;
			min_mapq_q      <= MIN_MAPQ_RESET;
			min_ident_q     <= MIN_IDENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_RADIUS:   window_radius_q <= cfg_data[RADIUS_CFG_W-1:0];
				REG_MIN_MAP_QUALITY: min_mapq_q      <= cfg_data[MAPQ_W-1:0];
				REG_MIN_IDENTITY:    min_ident_q     <= cfg_data[IDENT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(window_radius_q) > MAX_RADIUS) r_eff = RAD_W'(MAX_RADIUS);
		else r_eff = RAD_W'(window_radius_q);
	end

	// Input column unpack
	always_comb begin
		in_col.qb   = s_tdata[7:0];
		in_col.qgap = s_tdata[8];
		in_col.rb   = s_tdata[16:9];
		in_col.rgap = s_tdata[17];
		in_col.snp  = s_tdata[18] & ~s_tdata[17];
		in_col.alt  = s_tdata[26:19];
		in_col.rph  = s_tdata[27];
		in_col.aph  = s_tdata[28];
	end

	assign s_tready = (state_q == ST_RUN);
	assign accept   = s_tvalid && s_tready;
	assign shift    = accept || ((state_q == ST_FLUSH) && (flush_cnt_q != '0));
	assign out_load = (state_q == ST_TAG) && (!m_tvalid_q || m_tready);
	assign clear    = out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			flush_cnt_q <= '0;
			judge_q     <= 1'b0;
		end else begin
			judge_q <= shift;
			unique case (state_q)
				ST_RUN: begin
					if (accept && s_tlast) begin
						state_q     <= ST_FLUSH;
						flush_cnt_q <= r_eff;
					end
				end
				ST_FLUSH: begin
					if (flush_cnt_q != '0) flush_cnt_q <= flush_cnt_q - RAD_W'(1);
					else state_q <= ST_TAG;
				end
				ST_TAG: begin
					if (out_load) state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// Fragment values of the last column
	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			mapq_q  <= s_tdata[36:29];
			ident_q <= s_tdata[50:37];
		end
	end

	// Cell chain: cell 0 takes the new column, or an empty slot while flushing
	for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			snp_hv_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.clear    (clear),
				.in_valid (accept),
				.in_col   (in_col),
				.out_valid(valids[g]),
				.out_col  (cols[g]),
				.ok       (oks[g])
			);
		end else begin : g_body
			snp_hv_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.clear    (clear),
				.in_valid (valids[g-1]),
				.in_col   (cols[g-1]),
				.out_valid(valids[g]),
				.out_col  (cols[g]),
				.ok       (oks[g])
			);
		end
	end

	snp_hv_judge u_judge (
		.en    (judge_q),
		.radius(r_eff),
		.valids(valids),
		.oks   (oks),
		.cols  (cols),
		.vote  (vote)
	);

	snp_hv_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.vote      (vote),
		.strict_dec(strict_dec),
		.loose_dec (loose_dec),
		.empty     (tally_empty)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			strict_tag_q <= ((mapq_q >= min_mapq_q) && (ident_q >= min_ident_q)) ?
				strict_dec : TAG_NONE;
			loose_tag_q  <= (mapq_q >= LOOSE_MIN_MAPQ) ? loose_dec : TAG_NONE;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2 * TAG_W){1'b0}}, loose_tag_q, strict_tag_q};

	assign frag_idle = (valids == '0) && tally_empty && !judge_q;

	`SNP_HV_ASSERT_NEXT(a_last_starts_flush, accept && s_tlast, state_q == ST_FLUSH, "no flush")
	`SNP_HV_ASSERT_NOW(a_flush_cnt_bound, state_q == ST_FLUSH, flush_cnt_q <= r_eff, "count high")
	`SNP_HV_ASSERT_NEXT(a_clear_after_tag, out_load, frag_idle, "fragment state not cleared")
	`SNP_HV_ASSERT_NOW(a_tag_from_flush, $rose(m_tvalid), $past(state_q == ST_TAG), "stray tag")

endmodule

/* tb/tb_snp_haplotype_vote_over_alignment_core.sv */
`timescale 1ns / 1ps

module tb_snp_haplotype_vote_over_alignment_core;
	import snp_hv_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PHASE_COLS  = 140;
	localparam logic [7:0] BASE_A = 8'h41;
	localparam logic [7:0] BASE_C = 8'h43;
	localparam logic [7:0] BASE_G = 8'h47;
	localparam logic [7:0] BASE_T = 8'h54;

	typedef struct packed {
		logic       valid;
		logic [7:0] qb;
		logic       qgap;
		logic [7:0] rb;
		logic       rgap;
		logic       snp;
		logic [7:0] alt;
		logic       rph;
		logic       aph;
	} aln_col_t;

	typedef struct {
		logic [IN_DATA_W-1:0] data;
		logic                 last;
	} col_beat_t;

	typedef struct {
		logic [TAG_W-1:0] strict_tag;
		logic [TAG_W-1:0] loose_tag;
	} tag_pair_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	// query_base, query_gap, ref_base, ref_gap, snp_here, snp_alt_base,
	// ref_phase, alt_phase, map_quality, identity, zero fill
	logic [IN_DATA_W-1:0]    s_tdata;
	logic                    s_tlast;
	logic                    m_tvalid;
	logic                    m_tready;
	// strict_tag, loose_tag, zero fill
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	col_beat_t col_q[$];
	tag_pair_t tag_q[$];

	// predicted block state
	aln_col_t                hist[WIN_DEPTH];
	logic [VOTE_W-1:0]       strict_one, strict_two, loose_one, loose_two;
	logic [RADIUS_CFG_W-1:0] radius_reg;
	logic [MAPQ_W-1:0]       min_mapq_reg;
	logic [IDENT_W-1:0]      min_ident_reg;

	int  fails;
	int  cols_taken;
	int  frags_taken;
	int  tags_seen;
	int  cycles;
	int  src_gap;
	int  src_calm;
	int  sink_hold;
	int  sink_calm;

	snp_haplotype_vote_over_alignment_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [VOTE_W-1:0] sat_inc(logic [VOTE_W-1:0] v);
		return (v == {VOTE_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag(logic [VOTE_W-1:0] one,
			logic [VOTE_W-1:0] two);
		if (one > two)
			return TAG_HAP1;
		if (one < two)
			return TAG_HAP2;
		return TAG_NONE;
	endfunction

	// SNP columns and empty slots never spoil a neighbor's window
	function automatic bit neighbor_clean(int idx);
		if (idx >= WIN_DEPTH)
			return 1'b1;
		if (!hist[idx].valid || hist[idx].snp)
			return 1'b1;
		if (hist[idx].qgap != hist[idx].rgap)
			return 1'b0;
		if (hist[idx].qgap)
			return 1'b1;
		return hist[idx].qb == hist[idx].rb;
	endfunction

	task automatic score_column(int p, int r);
		aln_col_t c;
		int       hap;
		bit       clean;
		if (p >= WIN_DEPTH)
			return;
		c = hist[p];
		if (!c.valid || !c.snp || c.qgap)
			return;
		hap = 0;
		if (c.qb == c.rb)
			hap = int'(c.rph) + 1;
		else if (c.qb == c.alt)
			hap = int'(c.aph) + 1;
		if (hap == 0)
			return;
		if (hap == 1)
			loose_one = sat_inc(loose_one);
		else
			loose_two = sat_inc(loose_two);
		clean = 1'b1;
		for (int i = 1; i <= r; i++) begin
			if (!neighbor_clean(p + i))
				clean = 1'b0;
			if (i <= p && !neighbor_clean(p - i))
				clean = 1'b0;
		end
		if (!clean)
			return;
		if (hap == 1)
			strict_one = sat_inc(strict_one);
		else
			strict_two = sat_inc(strict_two);
	endtask

	task automatic clear_fragment();
		for (int k = 0; k < WIN_DEPTH; k++)
			hist[k] = '0;
		strict_one = '0;
		strict_two = '0;
		loose_one  = '0;
		loose_two  = '0;
	endtask

	// Shift one accepted column in; on the last column flush and predict the tags
	task automatic take_column(logic [IN_DATA_W-1:0] d, logic last);
		aln_col_t          c;
		int                r;
		logic [MAPQ_W-1:0] mapq;
		logic [IDENT_W-1:0] ident;
		tag_pair_t         t;
		r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
		c.valid = 1'b1;
		c.qb    = d[7:0];
		c.qgap  = d[8];
		c.rb    = d[16:9];
		c.rgap  = d[17];
		c.snp   = d[18] & ~d[17];
		c.alt   = d[26:19];
		c.rph   = d[27];
		c.aph   = d[28];
		mapq    = d[36:29];
		ident   = d[50:37];
		for (int k = WIN_DEPTH - 1; k > 0; k--)
			hist[k] = hist[k-1];
		hist[0] = c;
		score_column(r, r);
		cols_taken++;
		if (!last)
			return;
		for (int k = r - 1; k >= 0; k--)
			score_column(k, r);
		t.strict_tag = (mapq >= min_mapq_reg && ident >= min_ident_reg) ?
			pick_tag(strict_one, strict_two) : TAG_NONE;
		t.loose_tag = (mapq >= LOOSE_MIN_MAPQ) ? pick_tag(loose_one, loose_two) : TAG_NONE;
		tag_q.insert(tag_q.size(), t);
		frags_taken++;
		clear_fragment();
	endtask

	function automatic int next_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 59) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// Column source: account for the beat taken at this edge, then present the next
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				take_column(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (col_q.size() != 0) begin
					col_beat_t b;
					b = col_q.pop_front();
					s_tdata  <= b.data;
					s_tlast  <= b.last;
					s_tvalid <= 1'b1;
					src_gap = next_gap(src_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Tag sink and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				tags_seen++;
				if (tag_q.size() == 0) begin
					$error("tag beat with none expected: strict_tag=%0d loose_tag=%0d",
						m_tdata[1:0], m_tdata[3:2]);
					fails++;
				end else begin
					tag_pair_t want;
					want = tag_q.pop_front();
					if (m_tdata[1:0] !== want.strict_tag) begin
						$error("strict_tag: expected %0d, got %0d", want.strict_tag,
							m_tdata[1:0]);
						fails++;
					end
					if (m_tdata[3:2] !== want.loose_tag) begin
						$error("loose_tag: expected %0d, got %0d", want.loose_tag,
							m_tdata[3:2]);
						fails++;
					end
				end
			end
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					sink_hold = next_gap(sink_calm);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("snp_haplotype_vote_over_alignment_core: mismatch");
			$finish;
		end
	end

	task automatic push_col(logic [7:0] qb, logic qgap, logic [7:0] rb, logic rgap,
			logic snp, logic [7:0] alt, logic rph, logic aph, logic [7:0] mapq,
			logic [13:0] ident, logic last);
		col_beat_t b;
		b.data = {5'b0, ident, mapq, aph, rph, alt, snp, rgap, rb, qgap, qb};
		b.last = last;
		col_q.insert(col_q.size(), b);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		unique case (idx)
			REG_WINDOW_RADIUS:   radius_reg    = val[RADIUS_CFG_W-1:0];
			REG_MIN_MAP_QUALITY: min_mapq_reg  = val[MAPQ_W-1:0];
			REG_MIN_IDENTITY:    min_ident_reg = val[IDENT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(int radius, int mapq, int ident);
		write_reg(REG_WINDOW_RADIUS, CFG_DATA_W'(radius));
		write_reg(REG_MIN_MAP_QUALITY, CFG_DATA_W'(mapq));
		write_reg(REG_MIN_IDENTITY, CFG_DATA_W'(ident));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every column is in and every tag is out, then let the flush settle
	task automatic drain();
		do
			@(negedge clk);
		while (col_q.size() != 0 || s_tvalid || tag_q.size() != 0);
		repeat (MAX_RADIUS + 8) @(negedge clk);
	endtask

	function automatic logic [7:0] any_base();
		if ($urandom_range(0, 9) < 8) begin
			case ($urandom_range(0, 3))
				0: return BASE_A;
				1: return BASE_C;
				2: return BASE_G;
				default: return BASE_T;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_mapq();
		int m;
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(0, 255));
			1: return 8'd255;
			2: return 8'($urandom_range(0, 10));
			3: begin
				m = int'(min_mapq_reg) + int'($urandom_range(0, 2)) - 1;
				return (m < 0) ? 8'd0 : (m > 255) ? 8'd255 : 8'(m);
			end
			default: return 8'($urandom_range(5, 60));
		endcase
	endfunction

	function automatic logic [13:0] pick_ident();
		int m;
		case ($urandom_range(0, 3))
			0: return 14'($urandom_range(0, 10000));
			1: return 14'd10000;
			2: return 14'($urandom_range(8400, 10000));
			default: begin
				m = int'(min_ident_reg) + int'($urandom_range(0, 2)) - 1;
				return (m < 0) ? 14'd0 : (m > 10000) ? 14'd10000 : 14'(m);
			end
		endcase
	endfunction

	task automatic add_random_fragment(int len);
		logic [7:0]  mapq, qb, rb, alt;
		logic [13:0] ident;
		logic        qgap, rgap, snp, rph, aph;
		bit          per_col;
		int          roll;
		mapq    = pick_mapq();
		ident   = pick_ident();
		per_col = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < len; i++) begin
			if (per_col) begin
				mapq  = pick_mapq();
				ident = pick_ident();
			end
			snp = ($urandom_range(0, 99) < 25);
			rb  = any_base();
			alt = any_base();
			if (alt == rb && $urandom_range(0, 9) != 0)
				alt = rb ^ 8'h02;
			rgap = ($urandom_range(0, 99) < 5);
			qgap = ($urandom_range(0, 99) < 6);
			roll = $urandom_range(0, 99);
			if (snp)
				qb = (roll < 40) ? rb : (roll < 80) ? alt : any_base();
			else
				qb = (roll < 90) ? rb : any_base();
			rph = 1'($urandom_range(0, 1));
			aph = ($urandom_range(0, 99) < 85) ? ~rph : 1'($urandom_range(0, 1));
			push_col(qb, qgap, rb, rgap, snp, alt, rph, aph, mapq, ident, i == len - 1);
		end
	endtask

	function automatic int pick_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 12);
		if (roll < 95)
			return $urandom_range(13, 30);
		return $urandom_range(31, 60);
	endfunction

	int radius_plan[6] = '{0, 8, 15, 1, 9, 5};
	int mapq_plan[6]   = '{0, 255, -1, 5, -1, -1};
	int ident_plan[6]  = '{0, 10000, -1, 8500, -1, -1};

	initial begin
		int phase_cols;
		int len;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		m_tready    = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		fails       = 0;
		cols_taken  = 0;
		frags_taken = 0;
		tags_seen   = 0;
		cycles      = 0;
		src_gap     = 0;
		src_calm    = 0;
		sink_hold   = 0;
		sink_calm   = 0;
		radius_reg    = RADIUS_RESET;
		min_mapq_reg  = MIN_MAPQ_RESET;
		min_ident_reg = MIN_IDENT_RESET;
		clear_fragment();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed fragments under the reset register values
		// lone SNP matching ref, top quality
		push_col(BASE_A, 1'b0, BASE_A, 1'b0, 1'b1, BASE_C, 1'b0, 1'b1, 8'd255, 14'd10000,
			1'b1);
		// lone SNP matching alt, quality exactly at both thresholds
		push_col(BASE_C, 1'b0, BASE_A, 1'b0, 1'b1, BASE_C, 1'b0, 1'b1, 8'd5, 14'd8500, 1'b1);
		// query gap at SNP, neither allele, then ref equal to alt (ref wins)
		push_col(BASE_A, 1'b1, BASE_A, 1'b0, 1'b1, BASE_C, 1'b0, 1'b1, 8'd200, 14'd8499,
			1'b0);
		push_col(BASE_T, 1'b0, BASE_A, 1'b0, 1'b1, BASE_C, 1'b0, 1'b1, 8'd200, 14'd8499,
			1'b0);
		push_col(BASE_G, 1'b0, BASE_G, 1'b0, 1'b1, BASE_G, 1'b1, 1'b0, 8'd200, 14'd8499,
			1'b1);
		// SNP mark on a reference gap spoils the next SNP's window; both-gap column
		push_col(BASE_A, 1'b0, BASE_A, 1'b1, 1'b1, BASE_C, 1'b0, 1'b1, 8'd5, 14'd10000,
			1'b0);
		push_col(BASE_A, 1'b0, BASE_A, 1'b0, 1'b1, BASE_C, 1'b0, 1'b1, 8'd5, 14'd10000,
			1'b0);
		push_col(BASE_T, 1'b1, BASE_T, 1'b1, 1'b0, BASE_C, 1'b0, 1'b1, 8'd5, 14'd10000,
			1'b0);
		push_col(BASE_G, 1'b0, BASE_G, 1'b0, 1'b0, BASE_C, 1'b0, 1'b1, 8'd5, 14'd10000,
			1'b1);
		// neighbor SNP with a bad query base is skipped by the window check
		push_col(BASE_C, 1'b0, BASE_C, 1'b0, 1'b0, BASE_A, 1'b0, 1'b1, 8'd255, 14'd10000,
			1'b0);
		push_col(BASE_C, 1'b0, BASE_A, 1'b0, 1'b1, BASE_C, 1'b0, 1'b1, 8'd255, 14'd10000,
			1'b0);
		push_col(BASE_T, 1'b0, BASE_G, 1'b0, 1'b1, BASE_A, 1'b1, 1'b0, 8'd255, 14'd10000,
			1'b0);
		push_col(BASE_A, 1'b1, BASE_A, 1'b1, 1'b0, BASE_C, 1'b0, 1'b1, 8'd255, 14'd10000,
			1'b0);
		push_col(8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd255, 1'b1, 1'b1, 8'd255, 14'd10000, 1'b1);
		// extreme bases, query-only gap, both tags gated off
		push_col(8'd255, 1'b0, 8'd255, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 8'd0, 14'd0, 1'b0);
		push_col(8'd0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 14'd0, 1'b1);
		// tie between the haplotypes
		push_col(BASE_A, 1'b0, BASE_A, 1'b0, 1'b1, BASE_T, 1'b0, 1'b1, 8'd100, 14'd9000,
			1'b0);
		push_col(BASE_T, 1'b0, BASE_A, 1'b0, 1'b1, BASE_T, 1'b0, 1'b1, 8'd100, 14'd9000,
			1'b0);
		push_col(BASE_G, 1'b0, BASE_G, 1'b0, 1'b0, BASE_T, 1'b0, 1'b1, 8'd100, 14'd9000,
			1'b1);
		// mismatch just outside the radius, window clipped at the fragment end
		push_col(BASE_T, 1'b0, BASE_A, 1'b0, 1'b0, BASE_C, 1'b0, 1'b1, 8'd5, 14'd8500, 1'b0);
		push_col(BASE_A, 1'b0, BASE_A, 1'b0, 1'b0, BASE_C, 1'b0, 1'b1, 8'd5, 14'd8500, 1'b0);
		push_col(BASE_C, 1'b0, BASE_C, 1'b0, 1'b0, BASE_A, 1'b0, 1'b1, 8'd5, 14'd8500, 1'b0);
		push_col(BASE_G, 1'b0, BASE_G, 1'b0, 1'b0, BASE_A, 1'b0, 1'b1, 8'd5, 14'd8500, 1'b0);
		push_col(BASE_A, 1'b0, BASE_A, 1'b0, 1'b1, BASE_G, 1'b0, 1'b1, 8'd5, 14'd8500, 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			configure(radius_plan[ph],
				(mapq_plan[ph] < 0) ? int'($urandom_range(0, 30)) : mapq_plan[ph],
				(ident_plan[ph] < 0) ? int'($urandom_range(7000, 10000)) : ident_plan[ph]);
			phase_cols = 0;
			while (phase_cols < PHASE_COLS) begin
				len = pick_length();
				add_random_fragment(len);
				phase_cols += len;
			end
			drain();
		end

		$display("%0d columns in %0d fragments fed, %0d tag beats checked", cols_taken,
			frags_taken, tags_seen);
		$display("radius settings 3 (directed corners), 0, 1, 5, 8, 9 and 15 (random)");
		if (fails == 0)
			$display("snp_haplotype_vote_over_alignment_core: match");
		else
			$display("snp_haplotype_vote_over_alignment_core: mismatch");
		$finish;
	end

endmodule
